>>> sv/prst_pkg.sv
// Shared types, constants and the sine table builder for the point transform core.
package prst_pkg;

    localparam int SINE_BITS_DEF   = 10;
    localparam int COORD_WIDTH_DEF = 32;

    localparam logic [15:0] ZOOM_MIN = 16'd6554;
    localparam logic [15:0] ZOOM_MAX = 16'd49152;
    localparam logic [15:0] ZOOM_ONE = 16'd16384;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Inverse numerator is |p - pan| * 2^14 + zoom/2, the quotient needs 34 bits.
    localparam int NUM_W     = 47;
    localparam int DIV_STEPS = 34;
    // Width of the forward result before saturation.
    localparam int FWD_W     = 41;

    typedef enum logic [2:0] {
        REG_ANGLE   = 3'd0,
        REG_PIVOT_X = 3'd1,
        REG_PIVOT_Y = 3'd2,
        REG_ZOOM    = 3'd3,
        REG_PAN_X   = 3'd4,
        REG_PAN_Y   = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [15:0]        angle;
        logic signed [31:0] pivot_x;
        logic signed [31:0] pivot_y;
        logic signed [31:0] pan_x;
        logic signed [31:0] pan_y;
    } t_cfg;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic             neg;
    } t_inv;

    typedef struct packed {
        t_inv                     inv;
        logic signed [FWD_W-1:0] fwd;
    } t_seed;

    typedef struct packed {
        t_seed                seed;
        logic [15:0]          rem;
        logic [DIV_STEPS-1:0] q;
    } t_lane;

    // One quarter-wave entry, sin(pi/2 * idx / 2^bits) in Q1.14, from a Taylor series.
    function automatic logic [14:0] sine_entry(input int unsigned idx, input int unsigned bits);
        longint unsigned n;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          q;
        n    = 64'd1 << bits;
        x    = (HALF_PI_Q30 * 64'(idx) + (n >> 1)) >> bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 7; k++) begin
            term = (term * x2) >> 30;
            case (k)
                1: term = term / 6;
                2: term = term / 20;
                3: term = term / 42;
                4: term = term / 72;
                5: term = term / 110;
                6: term = term / 156;
                default: term = term / 210;
            endcase
            if ((k & 1) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        q = (sum + 32768) >>> 16;
        if (q > 16384) begin
            q = 16384;
        end
        return 15'(q);
    endfunction

endpackage

>>> sv/prst_front.sv
// Six-stage front end: table lookup, rotation, zoom and pan, and the inverse numerator.
module prst_front import prst_pkg::*; #(
    parameter int SINE_TABLE_BITS = SINE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic               i_kind,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  t_cfg               i_cfg,
    input  logic [15:0]        i_zoom,
    output logic               o_valid,
    output logic               o_kind,
    output t_seed              o_seed_x,
    output t_seed              o_seed_y
);

    localparam int IW        = SINE_TABLE_BITS + 1;
    localparam int TABLE_LEN = (1 << SINE_TABLE_BITS) + 1;
    localparam int SHIFT     = 14 - SINE_TABLE_BITS;
    localparam int HALF      = (SHIFT > 0) ? ((1 << SHIFT) >> 1) : 0;
    localparam logic [IW-1:0] N_IDX = IW'(1 << SINE_TABLE_BITS);

    logic [14:0] w_rom [TABLE_LEN];

    for (genvar g = 0; g < TABLE_LEN; g++) begin : g_rom
        assign w_rom[g] = sine_entry(g, SINE_TABLE_BITS);
    end

    function automatic logic [IW-1:0] rom_addr(input logic [15:0] a);
        logic [14:0]   sum;
        logic [IW-1:0] idx;
        sum = {1'b0, a[13:0]} + 15'(HALF);
        idx = IW'(sum >> SHIFT);
        if (idx > N_IDX) begin
            idx = N_IDX;
        end
        return a[14] ? (N_IDX - idx) : idx;
    endfunction

    logic [5:0] r_v;

    // Stage 1
    logic               r1_kind, r1_rot, r1_sn, r1_cn;
    logic signed [31:0] r1_px, r1_py;
    logic signed [32:0] r1_dx, r1_dy, r1_ix, r1_iy;
    logic [IW-1:0]      r1_sa, r1_ca;
    // Stage 2
    logic               r2_kind, r2_rot;
    logic signed [31:0] r2_px, r2_py;
    logic signed [32:0] r2_dx, r2_dy;
    logic signed [15:0] r2_s, r2_c;
    t_inv               r2_ix, r2_iy;
    // Stage 3
    logic               r3_kind, r3_rot;
    logic signed [31:0] r3_px, r3_py;
    logic signed [48:0] r3_p0, r3_p1, r3_p2, r3_p3;
    t_inv               r3_ix, r3_iy;
    // Stage 4
    logic               r4_kind;
    logic signed [36:0] r4_wx, r4_wy;
    t_inv               r4_ix, r4_iy;
    // Stage 5
    logic               r5_kind;
    logic signed [53:0] r5_mx, r5_my;
    t_inv               r5_ix, r5_iy;
    // Stage 6
    logic               r6_kind;
    t_seed              r6_sx, r6_sy;

    logic [15:0]        w_cos_angle;
    logic signed [32:0] w_ix, w_iy;
    logic [32:0]        w_abs_x, w_abs_y;
    logic signed [49:0] w_sum_x, w_sum_y;
    logic signed [36:0] w_rot_x, w_rot_y;
    logic signed [53:0] w_rnd_x, w_rnd_y;
    logic signed [40:0] w_fwd_x, w_fwd_y;

    assign w_cos_angle = i_cfg.angle + ZOOM_ONE;
    assign w_ix = $signed({i_point_x[31], i_point_x}) - $signed({i_cfg.pan_x[31], i_cfg.pan_x});
    assign w_iy = $signed({i_point_y[31], i_point_y}) - $signed({i_cfg.pan_y[31], i_cfg.pan_y});

    assign w_abs_x = r1_ix[32] ? 33'(-r1_ix) : 33'(r1_ix);
    assign w_abs_y = r1_iy[32] ? 33'(-r1_iy) : 33'(r1_iy);

    assign w_sum_x = r3_p0 - r3_p1 + 50'sd8192;
    assign w_sum_y = r3_p2 + r3_p3 + 50'sd8192;
    assign w_rot_x = $signed(w_sum_x[49:14]) + $signed(i_cfg.pivot_x);
    assign w_rot_y = $signed(w_sum_y[49:14]) + $signed(i_cfg.pivot_y);

    assign w_rnd_x = r5_mx + 54'sd8192;
    assign w_rnd_y = r5_my + 54'sd8192;
    assign w_fwd_x = $signed(w_rnd_x[53:14]) + $signed(i_cfg.pan_x);
    assign w_fwd_y = $signed(w_rnd_y[53:14]) + $signed(i_cfg.pan_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_kind <= i_kind;
            r1_rot  <= (i_cfg.angle != 16'd0);
            r1_px   <= i_point_x;
            r1_py   <= i_point_y;
            r1_dx   <= $signed({i_point_x[31], i_point_x})
                       - $signed({i_cfg.pivot_x[31], i_cfg.pivot_x});
            r1_dy   <= $signed({i_point_y[31], i_point_y})
                       - $signed({i_cfg.pivot_y[31], i_cfg.pivot_y});
            r1_ix   <= w_ix;
            r1_iy   <= w_iy;
            r1_sa   <= rom_addr(i_cfg.angle);
            r1_ca   <= rom_addr(w_cos_angle);
            r1_sn   <= i_cfg.angle[15];
            r1_cn   <= w_cos_angle[15];

            r2_kind <= r1_kind;
            r2_rot  <= r1_rot;
            r2_px   <= r1_px;
            r2_py   <= r1_py;
            r2_dx   <= r1_dx;
            r2_dy   <= r1_dy;
            r2_s    <= r1_sn ? -$signed({1'b0, w_rom[r1_sa]}) : $signed({1'b0, w_rom[r1_sa]});
            r2_c    <= r1_cn ? -$signed({1'b0, w_rom[r1_ca]}) : $signed({1'b0, w_rom[r1_ca]});
            r2_ix   <= '{num: {w_abs_x, 14'd0} + NUM_W'(i_zoom >> 1), neg: r1_ix[32]};
            r2_iy   <= '{num: {w_abs_y, 14'd0} + NUM_W'(i_zoom >> 1), neg: r1_iy[32]};

            r3_kind <= r2_kind;
            r3_rot  <= r2_rot;
            r3_px   <= r2_px;
            r3_py   <= r2_py;
            r3_p0   <= r2_dx * r2_c;
            r3_p1   <= r2_dy * r2_s;
            r3_p2   <= r2_dx * r2_s;
            r3_p3   <= r2_dy * r2_c;
            r3_ix   <= r2_ix;
            r3_iy   <= r2_iy;

            // A zero angle passes the point on untouched.
            r4_kind <= r3_kind;
            r4_wx   <= r3_rot ? w_rot_x : 37'(r3_px);
            r4_wy   <= r3_rot ? w_rot_y : 37'(r3_py);
            r4_ix   <= r3_ix;
            r4_iy   <= r3_iy;

            r5_kind <= r4_kind;
            r5_mx   <= r4_wx * $signed({1'b0, i_zoom});
            r5_my   <= r4_wy * $signed({1'b0, i_zoom});
            r5_ix   <= r4_ix;
            r5_iy   <= r4_iy;

            r6_kind <= r5_kind;
            r6_sx   <= '{inv: r5_ix, fwd: w_fwd_x};
            r6_sy   <= '{inv: r5_iy, fwd: w_fwd_y};
        end
    end

    assign o_valid  = r_v[5];
    assign o_kind   = r6_kind;
    assign o_seed_x = r6_sx;
    assign o_seed_y = r6_sy;

endmodule

>>> sv/prst_divider.sv
// Pipelined restoring divider, one quotient bit per stage, forward results ride along.
module prst_divider import prst_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic        i_kind,
    input  t_seed       i_seed_x,
    input  t_seed       i_seed_y,
    input  logic [15:0] i_zoom,
    output logic        o_valid,
    output logic        o_kind,
    output t_lane       o_lane_x,
    output t_lane       o_lane_y
);

    logic [DIV_STEPS-1:0] r_v;
    logic [DIV_STEPS-1:0] r_k;
    t_lane                r_x [DIV_STEPS];
    t_lane                r_y [DIV_STEPS];

    function automatic t_lane div_step(input t_lane l, input logic [15:0] z, input int k);
        logic [16:0] t;
        t_lane       o;
        o = l;
        t = {l.rem, l.seed.inv.num[k]};
        if (t >= {1'b0, z}) begin
            t      = t - {1'b0, z};
            o.q[k] = 1'b1;
        end
        o.rem = t[15:0];
        return o;
    endfunction

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
        localparam int K = DIV_STEPS - 1 - j;
        t_lane w_prev_x, w_prev_y;

        if (j == 0) begin : g_first
            // The top numerator bits are always below the zoom, so they seed the remainder.
            assign w_prev_x = '{seed: i_seed_x,
                                rem: 16'(i_seed_x.inv.num[NUM_W-1:DIV_STEPS]), q: '0};
            assign w_prev_y = '{seed: i_seed_y,
                                rem: 16'(i_seed_y.inv.num[NUM_W-1:DIV_STEPS]), q: '0};
        end else begin : g_rest
            assign w_prev_x = r_x[j-1];
            assign w_prev_y = r_y[j-1];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[j] <= div_step(w_prev_x, i_zoom, K);
                r_y[j] <= div_step(w_prev_y, i_zoom, K);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[DIV_STEPS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_k <= {r_k[DIV_STEPS-2:0], i_kind};
        end
    end

    assign o_valid  = r_v[DIV_STEPS-1];
    assign o_kind   = r_k[DIV_STEPS-1];
    assign o_lane_x = r_x[DIV_STEPS-1];
    assign o_lane_y = r_y[DIV_STEPS-1];

endmodule

>>> sv/point_rotate_scale_translate_core.sv
// Top level of the 2D rotate, zoom and pan point transform core.
//
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_ready    i_kind, i_point_x, i_point_y
//  result    out        o_out_valid / i_out_ready  o_result_x, o_result_y, o_saturated
//  config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// One word enters per cycle while the output is not stalled; each result passes six front stages,
// 34 divider stages for the one-bit-per-stage inverse quotient and one output register.
// Synchronous active-low reset clears the valid bits and loads the register defaults.
// A stalled output freezes the whole pipeline, so nothing is dropped or repeated.
module point_rotate_scale_translate_core import prst_pkg::*; #(
    parameter int SINE_TABLE_BITS = SINE_BITS_DEF,
    parameter int COORD_WIDTH     = COORD_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_kind,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_result_x,
    output logic signed [31:0] o_result_y,
    output logic               o_saturated,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int SAT_W = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam logic signed [FWD_W-1:0] SAT_HI = FWD_W'((64'sd1 <<< (SAT_W - 1)) - 64'sd1);
    localparam logic signed [FWD_W-1:0] SAT_LO = -SAT_HI - FWD_W'(1);

    t_cfg        r_cfg;
    logic [15:0] r_zoom;
    logic [15:0] w_zoom;
    logic        w_en;

    logic        w_f_valid, w_f_kind, w_d_valid, w_d_kind;
    t_seed       w_seed_x, w_seed_y;
    t_lane       w_lane_x, w_lane_y;

    logic signed [FWD_W-1:0] w_val_x, w_val_y, w_sat_x, w_sat_y;
    logic                    w_clip_x, w_clip_y;

    logic               r_out_valid;
    logic signed [31:0] r_out_x, r_out_y;
    logic               r_out_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg  <= '{angle: 16'd0, pivot_x: 32'sd0, pivot_y: 32'sd0,
                        pan_x: 32'sd0, pan_y: 32'sd0};
            r_zoom <= ZOOM_ONE;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_ANGLE:   r_cfg.angle   <= i_cfg_data[15:0];
                REG_PIVOT_X: r_cfg.pivot_x <= i_cfg_data;
                REG_PIVOT_Y: r_cfg.pivot_y <= i_cfg_data;
                REG_ZOOM:    r_zoom        <= i_cfg_data[15:0];
                REG_PAN_X:   r_cfg.pan_x   <= i_cfg_data;
                REG_PAN_Y:   r_cfg.pan_y   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Out-of-range zoom is clamped on use, which also keeps the divisor nonzero.
    assign w_zoom = (r_zoom < ZOOM_MIN) ? ZOOM_MIN : ((r_zoom > ZOOM_MAX) ? ZOOM_MAX : r_zoom);

    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    prst_front #(
        .SINE_TABLE_BITS(SINE_TABLE_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_in_valid),
        .i_kind    (i_kind),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_cfg     (r_cfg),
        .i_zoom    (w_zoom),
        .o_valid   (w_f_valid),
        .o_kind    (w_f_kind),
        .o_seed_x  (w_seed_x),
        .o_seed_y  (w_seed_y)
    );

    prst_divider u_divider (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (w_f_valid),
        .i_kind   (w_f_kind),
        .i_seed_x (w_seed_x),
        .i_seed_y (w_seed_y),
        .i_zoom   (w_zoom),
        .o_valid  (w_d_valid),
        .o_kind   (w_d_kind),
        .o_lane_x (w_lane_x),
        .o_lane_y (w_lane_y)
    );

    assign w_val_x = !w_d_kind ? w_lane_x.seed.fwd :
                     (w_lane_x.seed.inv.neg ? -$signed(FWD_W'(w_lane_x.q))
                                            : $signed(FWD_W'(w_lane_x.q)));
    assign w_val_y = !w_d_kind ? w_lane_y.seed.fwd :
                     (w_lane_y.seed.inv.neg ? -$signed(FWD_W'(w_lane_y.q))
                                            : $signed(FWD_W'(w_lane_y.q)));

    assign w_clip_x = (w_val_x > SAT_HI) || (w_val_x < SAT_LO);
    assign w_clip_y = (w_val_y > SAT_HI) || (w_val_y < SAT_LO);
    assign w_sat_x  = (w_val_x > SAT_HI) ? SAT_HI : ((w_val_x < SAT_LO) ? SAT_LO : w_val_x);
    assign w_sat_y  = (w_val_y > SAT_HI) ? SAT_HI : ((w_val_y < SAT_LO) ? SAT_LO : w_val_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_x   <= w_sat_x[31:0];
            r_out_y   <= w_sat_y[31:0];
            r_out_sat <= w_clip_x || w_clip_y;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result_x  = r_out_x;
    assign o_result_y  = r_out_y;
    assign o_saturated = r_out_sat;

endmodule

>>> sv/prst_checker.sv
// Port-level checks for the point transform core, bound to the top level.
module prst_checker import prst_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] o_result_x,
    input logic signed [31:0] o_result_y,
    input logic               o_saturated
);

    localparam int SAT_W = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam logic signed [31:0] HI = 32'((64'sd1 <<< (SAT_W - 1)) - 64'sd1);
    localparam logic signed [31:0] LO = -HI - 32'sd1;

    // The input side is only held back by a full, stalled output register.
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input stalled while output can move");

    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result word right after reset");

    // A clipped word carries at least one coordinate at a range limit.
    a_flag_means_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
        (o_result_x == HI || o_result_x == LO || o_result_y == HI || o_result_y == LO))
        else $error("saturation flag without a limit value");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_result_x)
                                           && $stable(o_result_y) && $stable(o_saturated)))
        else $error("result word changed while stalled");

endmodule

bind point_rotate_scale_translate_core prst_checker #(
    .COORD_WIDTH(COORD_WIDTH)
) u_prst_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_result_x  (o_result_x),
    .o_result_y  (o_result_y),
    .o_saturated (o_saturated)
);

>>> dv/tb_top.sv
// Self-checking testbench for the point rotate, zoom and pan transform core.
module tb_top;
    import prst_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_FWD = 1'b0;
    localparam logic KIND_INV = 1'b1;
    localparam int HOLD_CYCLES = 300;
    localparam int FLUSH_CYCLES = 50;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               sat;
    } t_point_out;

    typedef struct {
        logic               kind;
        logic signed [31:0] x;
        logic signed [31:0] y;
        bit                 typed;
        t_point_out         want;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               o_in_ready;
    logic               kind = 1'b0;
    logic signed [31:0] point_x = '0;
    logic signed [31:0] point_y = '0;
    logic               o_out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] o_result_x;
    logic signed [31:0] o_result_y;
    logic               o_saturated;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;

    point_rotate_scale_translate_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (kind),
        .i_point_x   (point_x),
        .i_point_y   (point_y),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_result_x  (o_result_x),
        .o_result_y  (o_result_y),
        .o_saturated (o_saturated),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Own copy of the register file and the quarter-wave table.
    logic [15:0] angle_q;
    longint      pivot_x_q, pivot_y_q, pan_x_q, pan_y_q;
    logic [15:0] zoom_q;
    longint      quarter_sine[0:1024];

    t_point_out  pending_points[$];
    int          errors = 0;
    int          n_fwd = 0, n_inv = 0, n_sat = 0, n_checked = 0;
    bit          gaps_on = 1'b1;
    bit          stall_req = 1'b0;

    function automatic void build_quarter_sine();
        longint unsigned x, x2, term;
        longint          sum, q;
        for (int i = 0; i <= 1024; i++) begin
            x = (64'd1686629713 * 64'(i) + 64'd512) >> 10;
            x2 = (x * x) >> 30;
            term = x;
            sum = longint'(x);
            for (int k = 1; k <= 7; k++) begin
                term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
                sum = (k % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
            end
            if (sum < 0) sum = 0;
            q = (sum + 32768) >>> 16;
            quarter_sine[i] = (q > 16384) ? 16384 : q;
        end
    endfunction

    function automatic longint lookup_sine(logic [15:0] a);
        int unsigned idx;
        longint      v;
        idx = (int'(a[13:0]) + 8) >> 4;
        if (idx > 1024) idx = 1024;
        v = a[14] ? quarter_sine[1024 - idx] : quarter_sine[idx];
        return a[15] ? -v : v;
    endfunction

    function automatic longint apply_zoom(longint v, longint z);
        longint hi, lo;
        hi = v >>> 14;
        lo = v - hi * 16384;
        return hi * z + ((lo * z + 8192) >>> 14);
    endfunction

    function automatic longint undo_zoom(longint d, longint z);
        longint          num;
        longint unsigned mag, q;
        num = d * 16384;
        mag = num < 0 ? longint'(-num) : num;
        q = (mag + longint'(z / 2)) / z;
        return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clip32(longint v, inout logic flag);
        if (v > 64'sd2147483647) begin
            flag = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            flag = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic t_point_out transform_point(logic k, logic signed [31:0] px,
                                                   logic signed [31:0] py);
        longint     z, rx, ry, wx, wy, s, c, dx, dy;
        t_point_out r;
        z = zoom_q;
        if (z < ZOOM_MIN) z = ZOOM_MIN;
        if (z > ZOOM_MAX) z = ZOOM_MAX;
        if (k == 1'b1) begin
            rx = undo_zoom(longint'(px) - pan_x_q, z);
            ry = undo_zoom(longint'(py) - pan_y_q, z);
        end else begin
            wx = px;
            wy = py;
            if (angle_q != 0) begin
                s = lookup_sine(angle_q);
                c = lookup_sine(angle_q + 16'd16384);
                dx = longint'(px) - pivot_x_q;
                dy = longint'(py) - pivot_y_q;
                wx = ((dx * c - dy * s + 8192) >>> 14) + pivot_x_q;
                wy = ((dx * s + dy * c + 8192) >>> 14) + pivot_y_q;
            end
            rx = apply_zoom(wx, z) + pan_x_q;
            ry = apply_zoom(wy, z) + pan_y_q;
        end
        r.sat = 1'b0;
        r.x = 32'(clip32(rx, r.sat));
        r.y = 32'(clip32(ry, r.sat));
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    // Call at a rising edge; leaves the caller at a rising edge with the enable still set.
    task automatic write_reg(t_reg_idx idx, logic [31:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_ANGLE:   angle_q = data[15:0];
            REG_PIVOT_X: pivot_x_q = longint'(signed'(data));
            REG_PIVOT_Y: pivot_y_q = longint'(signed'(data));
            REG_ZOOM:    zoom_q = data[15:0];
            REG_PAN_X:   pan_x_q = longint'(signed'(data));
            REG_PAN_Y:   pan_y_q = longint'(signed'(data));
            default: ;
        endcase
    endtask

    task automatic load_setting(logic [15:0] a, logic [31:0] pvx, logic [31:0] pvy,
                                logic [15:0] z, logic [31:0] pnx, logic [31:0] pny);
        write_reg(REG_ANGLE, {16'd0, a});
        write_reg(REG_PIVOT_X, pvx);
        write_reg(REG_PIVOT_Y, pvy);
        write_reg(REG_ZOOM, {16'd0, z});
        write_reg(REG_PAN_X, pnx);
        write_reg(REG_PAN_Y, pny);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (FLUSH_CYCLES) @(posedge i_clk);
    endtask

    // Offers one word and returns at the edge where it was accepted.
    task automatic send_word(logic k, logic signed [31:0] x, logic signed [31:0] y,
                             bit typed, t_point_out want);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        point_x <= x;
        point_y <= y;
        do @(posedge i_clk); while (!o_in_ready);
        pending_points.push_back(typed ? want : transform_point(k, x, y));
        if (k) n_inv++; else n_fwd++;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'(signed'($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
            2: return 32'(signed'($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000);
            default: return 32'(signed'($urandom_range(0, 32'h0001_FFFF)) - 32'sh0001_0000);
        endcase
    endfunction

    t_row directed[$];

    function automatic t_row make_row(logic k, logic [31:0] x, logic [31:0] y, bit typed,
                                      logic [31:0] ex, logic [31:0] ey, logic es);
        t_row r;
        r.kind = k;
        r.x = x;
        r.y = y;
        r.typed = typed;
        r.want.x = ex;
        r.want.y = ey;
        r.want.sat = es;
        return r;
    endfunction

    // Receiver: random back-pressure, plus one long hold when asked.
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                stall_req = 1'b0;
                out_ready <= 1'b1;
            end else if (i_rst_n && gaps_on && $urandom_range(0, 7) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= i_rst_n;
            end
        end
    end

    always @(posedge i_clk) begin
        t_point_out want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (pending_points.size() == 0) begin
                $display("[%0t] result word with no expectation waiting", $realtime);
                errors++;
            end else begin
                want = pending_points.pop_front();
                n_checked++;
                if (o_saturated) n_sat++;
                if (o_result_x !== want.x) report_mismatch("result_x", o_result_x, want.x);
                if (o_result_y !== want.y) report_mismatch("result_y", o_result_y, want.y);
                if (o_saturated !== want.sat)
                    report_mismatch("saturated", o_saturated, want.sat);
            end
        end
    end

    initial begin
        #3_000_000;
        $display("Timeout with %0d results outstanding", pending_points.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        t_point_out  nothing;
        logic [15:0] ext_angle[6];
        logic [15:0] ext_zoom[6];
        int          phase_items;

        ext_angle = '{16'hFFFF, 16'h4000, 16'h8000, 16'hC000, 16'h0001, 16'h2000};
        ext_zoom = '{16'd0, 16'hFFFF, 16'd6554, 16'd49152, 16'd6553, 16'd49153};
        nothing = '{x: '0, y: '0, sat: 1'b0};
        build_quarter_sine();
        angle_q = 0; pivot_x_q = 0; pivot_y_q = 0; zoom_q = ZOOM_ONE; pan_x_q = 0; pan_y_q = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset setting: zero angle and unity zoom pass every point through exactly.
        directed.push_back(make_row(KIND_FWD, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
                                    32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
        directed.push_back(make_row(KIND_FWD, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1,
                                    32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
        directed.push_back(make_row(KIND_INV, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1,
                                    32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
        directed.push_back(make_row(KIND_INV, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
                                    32'h0000_0000, 32'hFFFF_FFFF, 1'b0));
        directed.push_back(make_row(KIND_FWD, 32'h0001_0000, 32'hFFFF_0000, 1'b1,
                                    32'h0001_0000, 32'hFFFF_0000, 1'b0));
        foreach (directed[i])
            send_word(directed[i].kind, directed[i].x, directed[i].y, directed[i].typed,
                      directed[i].want);
        in_valid <= 1'b0;
        wait_idle();

        // Extreme settings: quadrant and other angles, zooms at and beyond the clamp limits, pans that force clipping.
        for (int p = 0; p < 6; p++) begin
            load_setting(ext_angle[p], p[0] ? 32'h8000_0000 : 32'h0100_0000,
                         p[1] ? 32'h7FFF_FFFF : 32'hFFF0_0000, ext_zoom[p],
                         p == 1 ? 32'h7FFF_FFFF : (p == 3 ? 32'h8000_0000 : 32'h0002_0000),
                         p == 1 ? 32'h8000_0000 : 32'hFFFE_0000);
            send_word(KIND_FWD, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, nothing);
            send_word(KIND_FWD, 32'h0003_0000, 32'h0005_8000, 1'b0, nothing);
            send_word(KIND_INV, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, nothing);
            in_valid <= 1'b0;
            wait_idle();
        end

        // Random settings with random words; the first phase holds the receiver off.
        for (int p = 0; p < 11; p++) begin
            load_setting($urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom),
                         rand_coord(), rand_coord(),
                         $urandom_range(0, 5) == 0 ? 16'($urandom)
                                                   : 16'($urandom_range(6554, 49152)),
                         rand_coord(), rand_coord());
            gaps_on = (p < 9);
            if (p == 0) stall_req = 1'b1;
            phase_items = 100;
            for (int n = 0; n < phase_items; n++)
                send_word(1'($urandom), rand_coord(), rand_coord(), 1'b0, nothing);
            in_valid <= 1'b0;
            wait_idle();
        end

        $display("Covered %0d forward and %0d inverse points over 18 settings,", n_fwd, n_inv);
        $display("%0d results checked, %0d of them clipped.", n_checked, n_sat);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
